FILE: rtl/core/pss_pkg.sv
// Shared types, constants and helpers of the power soft-start sequencer.
`default_nettype none

package pss_pkg;

  // Datapath widths.
  localparam int REF_BITS   = 12;
  localparam int COUNT_BITS = 16;
  localparam int DELAY_BITS = 16;
  localparam int STEP_BITS  = 8;

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  // Stream beat widths, padded to whole bytes.
  localparam int IN_ITEM_W  = 5 + REF_BITS;
  localparam int IN_DATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
  localparam int OUT_ITEM_W = 3 + 3 + 1 + 1 + REF_BITS + 2;
  localparam int OUT_DATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

  // Configuration register map.
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_ON_DELAY   = 2'd0;
  localparam logic [1:0] REG_GOOD_DELAY = 2'd1;
  localparam logic [1:0] REG_RAMP_STEP  = 2'd2;
  localparam logic [1:0] REG_AUTO_GO    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [DELAY_BITS-1:0] ON_DELAY_RST   = DELAY_BITS'(500);
  localparam logic [DELAY_BITS-1:0] GOOD_DELAY_RST = DELAY_BITS'(200);
  localparam logic [STEP_BITS-1:0]  RAMP_STEP_RST  = STEP_BITS'(4);

  // Operating status codes.
  localparam logic [2:0] ST_OFF      = 3'd0;
  localparam logic [2:0] ST_STANDBY  = 3'd1;
  localparam logic [2:0] ST_STARTING = 3'd2;
  localparam logic [2:0] ST_ON       = 3'd3;
  localparam logic [2:0] ST_FAULT    = 3'd4;

  // Peripheral command codes.
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_INIT   = 2'd1;
  localparam logic [1:0] CMD_LAUNCH = 2'd2;

  // Sequence phases, one-hot.
  typedef enum logic [7:0] {
    PH_INIT     = 8'b0000_0001,
    PH_LAUNCH   = 8'b0000_0010,
    PH_STANDBY  = 8'b0000_0100,
    PH_ON_DELAY = 8'b0000_1000,
    PH_RAMP     = 8'b0001_0000,
    PH_GOOD_DLY = 8'b0010_0000,
    PH_COMPLETE = 8'b0100_0000,
    PH_FAULT    = 8'b1000_0000
  } pss_phase_t;

  // Phase number as reported on the result beat.
  localparam logic [2:0] PHN_INIT     = 3'd0;
  localparam logic [2:0] PHN_LAUNCH   = 3'd1;
  localparam logic [2:0] PHN_STANDBY  = 3'd2;
  localparam logic [2:0] PHN_ON_DELAY = 3'd3;
  localparam logic [2:0] PHN_RAMP     = 3'd4;
  localparam logic [2:0] PHN_GOOD_DLY = 3'd5;
  localparam logic [2:0] PHN_COMPLETE = 3'd6;
  localparam logic [2:0] PHN_FAULT    = 3'd7;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [REF_BITS-1:0] target_ref;
    logic                go_in;
    logic                enable_in;
    logic                fault_trip;
    logic                fault_clear;
    logic                adc_seen;
  } pss_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]          peripheral_cmd;
    logic [REF_BITS-1:0] loop_reference;
    logic                loop_enable;
    logic                pwm_enable;
    logic [2:0]          phase_now;
    logic [2:0]          run_status;
  } pss_result_t;

  // Configuration seen by the step logic.
  typedef struct packed {
    logic [DELAY_BITS-1:0] on_delay_ticks;
    logic [DELAY_BITS-1:0] good_delay_ticks;
    logic [STEP_BITS-1:0]  ramp_step;
    logic                  auto_go;
  } pss_cfg_t;

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    pss_phase_t            phase;
    logic [COUNT_BITS-1:0] tick_count;
    logic [REF_BITS-1:0]   ramp_reference;
    logic                  use_ramp_reference;
    logic                  enable_latch;
    logic                  go_latch;
    logic                  adc_armed;
    logic                  fault_latched;
    logic                  pwm_on;
    logic                  loop_on;
  } pss_state_t;

  localparam pss_state_t STATE_RST = '{
    phase:              PH_INIT,
    tick_count:         '0,
    ramp_reference:     '0,
    use_ramp_reference: 1'b0,
    enable_latch:       1'b0,
    go_latch:           1'b0,
    adc_armed:          1'b0,
    fault_latched:      1'b0,
    pwm_on:             1'b0,
    loop_on:            1'b0
  };

  // Encode a one-hot phase into its reported number.
  function automatic logic [2:0] phase_num(input pss_phase_t ph);
    logic [2:0] n;
    case (ph)
      PH_INIT:     n = PHN_INIT;
      PH_LAUNCH:   n = PHN_LAUNCH;
      PH_STANDBY:  n = PHN_STANDBY;
      PH_ON_DELAY: n = PHN_ON_DELAY;
      PH_RAMP:     n = PHN_RAMP;
      PH_GOOD_DLY: n = PHN_GOOD_DLY;
      PH_COMPLETE: n = PHN_COMPLETE;
      default:     n = PHN_FAULT;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/power_soft_start_sequencer.sv
// Top level of the power soft-start sequencer: stream ports, APB registers, pipeline.
`default_nettype none

// Each input beat is one scheduler tick; it yields exactly one result beat that
// reports the phase, status, enables and loop reference after that tick. The
// block takes one beat per clock while the output side is ready: a beat lands
// in an input register and the tick logic carries it from there into the
// output register, which presents the result beat until out_tready takes it.
// The output register lets the next tick be accepted while a result still
// waits; throughput then follows out_tready. Registers are written over the APB
// port at byte addresses 0 (power-on delay), 4 (power-good delay), 8 (ramp
// step) and 12 (auto start), and should be changed only while the block is idle.

module power_soft_start_sequencer import pss_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream; tdata from bit 0: adc_seen, fault_clear, fault_trip,
  // enable_in, go_in, target_ref, zero padding.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream; tdata from bit 0: run_status, phase_now, pwm_enable,
  // loop_enable, loop_reference, peripheral_cmd, zero padding.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  pss_cfg_t    cfg_r;
  pss_state_t  state_r;
  pss_state_t  state_nxt;
  pss_item_t   in_item_r;
  logic        in_valid_r;
  pss_result_t out_res_r;
  pss_result_t res_nxt;
  logic        out_valid_r;
  logic        advance;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_delay_ticks   <= ON_DELAY_RST;
      cfg_r.good_delay_ticks <= GOOD_DELAY_RST;
      cfg_r.ramp_step        <= RAMP_STEP_RST;
      cfg_r.auto_go          <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ON_DELAY:   cfg_r.on_delay_ticks   <= cfg_pwdata[DELAY_BITS-1:0];
        REG_GOOD_DELAY: cfg_r.good_delay_ticks <= cfg_pwdata[DELAY_BITS-1:0];
        REG_RAMP_STEP:  cfg_r.ramp_step        <= cfg_pwdata[STEP_BITS-1:0];
        REG_AUTO_GO:    cfg_r.auto_go          <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_ON_DELAY:   cfg_prdata = 32'(cfg_r.on_delay_ticks);
      REG_GOOD_DELAY: cfg_prdata = 32'(cfg_r.good_delay_ticks);
      REG_RAMP_STEP:  cfg_prdata = 32'(cfg_r.ramp_step);
      REG_AUTO_GO:    cfg_prdata = 32'(cfg_r.auto_go);
      default:        cfg_prdata = '0;
    endcase
  end

  // The held tick moves on whenever the output register is free or draining.
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_tdata[IN_ITEM_W-1:0];
    end
  end

  // Tick logic.
  pss_step u_step (
    .st     (state_r),
    .cfg    (cfg_r),
    .item   (in_item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Sequencer state advances once per processed tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

  // A held tick that cannot move on stays held.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("held tick dropped without being processed");

  // A fault tick always reports the standby phase.
  a_fault_standby: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.run_status == ST_FAULT |->
      out_res_r.phase_now == PHN_STANDBY)
    else $error("fault result not followed by standby phase");

  // Peripheral commands only come with the off status.
  a_cmd_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.peripheral_cmd != CMD_NONE |->
      out_res_r.run_status == ST_OFF)
    else $error("peripheral command outside init or launch");

  // The PWM never runs while the status says standby.
  a_standby_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.run_status == ST_STANDBY |->
      !out_res_r.pwm_enable && !out_res_r.loop_enable)
    else $error("PWM or loop active in standby");

endmodule

`default_nettype wire

FILE: rtl/core/pss_step.sv
// Next-state and result logic for one scheduler tick of the sequencer.
`default_nettype none

module pss_step import pss_pkg::*; (
  input  pss_state_t  st,
  input  pss_cfg_t    cfg,
  input  pss_item_t   item,
  output pss_state_t  st_nxt,
  output pss_result_t res
);

  logic                  enable;
  logic                  go;
  pss_phase_t            cur;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  on_done;
  logic                  good_done;
  logic [REF_BITS:0]     ramp_sum;
  logic [REF_BITS-1:0]   ramp_sat;
  logic [2:0]            status;
  logic [1:0]            cmd;

  // Event flags, ramp adder and delay compares.
  assign enable    = item.enable_in | st.enable_latch;
  assign go        = item.go_in | st.go_latch;
  assign cur       = item.fault_trip ? PH_FAULT : st.phase;
  assign count_inc = st.tick_count + COUNT_BITS'(1);
  assign on_done   = 32'(st.tick_count) > 32'(cfg.on_delay_ticks);
  assign good_done = 32'(st.tick_count) > 32'(cfg.good_delay_ticks);
  assign ramp_sum  = {1'b0, st.ramp_reference} + (REF_BITS + 1)'(cfg.ramp_step);
  assign ramp_sat  = ramp_sum[REF_BITS] ? REF_MAX : ramp_sum[REF_BITS-1:0];

  // Phase transitions.
  always_comb begin
    st_nxt = st;
    status = ST_OFF;
    cmd    = CMD_NONE;
    if (item.adc_seen) begin
      st_nxt.adc_armed = 1'b1;
    end
    if (item.fault_clear) begin
      st_nxt.fault_latched = 1'b0;
    end
    case (cur)
      PH_INIT: begin
        cmd                       = CMD_INIT;
        st_nxt.tick_count         = '0;
        st_nxt.ramp_reference     = '0;
        st_nxt.use_ramp_reference = 1'b0;
        st_nxt.loop_on            = 1'b0;
        st_nxt.phase              = PH_LAUNCH;
      end
      PH_LAUNCH: begin
        cmd          = CMD_LAUNCH;
        st_nxt.phase = PH_STANDBY;
      end
      PH_STANDBY: begin
        status         = ST_STANDBY;
        st_nxt.pwm_on  = 1'b0;
        st_nxt.loop_on = 1'b0;
        if (enable && st_nxt.adc_armed && !st_nxt.fault_latched && go) begin
          st_nxt.tick_count = '0;
          st_nxt.phase      = PH_ON_DELAY;
        end
      end
      PH_ON_DELAY: begin
        status            = ST_STARTING;
        st_nxt.tick_count = count_inc;
        if (on_done) begin
          st_nxt.tick_count         = '0;
          st_nxt.ramp_reference     = '0;
          st_nxt.use_ramp_reference = 1'b1;
          st_nxt.phase              = PH_RAMP;
        end
      end
      PH_RAMP: begin
        status                = ST_STARTING;
        st_nxt.pwm_on         = 1'b1;
        st_nxt.loop_on        = 1'b1;
        st_nxt.ramp_reference = ramp_sat;
        if (ramp_sat >= item.target_ref) begin
          st_nxt.tick_count = '0;
          st_nxt.phase      = PH_GOOD_DLY;
        end
      end
      PH_GOOD_DLY: begin
        status            = ST_STARTING;
        st_nxt.tick_count = count_inc;
        if (good_done) begin
          st_nxt.tick_count = '0;
          st_nxt.phase      = PH_COMPLETE;
        end
      end
      PH_COMPLETE: begin
        status                    = ST_ON;
        st_nxt.use_ramp_reference = 1'b0;
      end
      default: begin
        status               = ST_FAULT;
        st_nxt.fault_latched = 1'b1;
        st_nxt.adc_armed     = 1'b0;
        st_nxt.phase         = PH_STANDBY;
      end
    endcase
    // Auto start holds both latches; otherwise go is a one-tick request.
    if (cfg.auto_go) begin
      st_nxt.enable_latch = 1'b1;
      st_nxt.go_latch     = 1'b1;
    end else begin
      st_nxt.go_latch = 1'b0;
    end
  end

  // Result beat built from the state after this tick.
  always_comb begin
    res.run_status     = status;
    res.phase_now      = phase_num(st_nxt.phase);
    res.pwm_enable     = st_nxt.pwm_on;
    res.loop_enable    = st_nxt.loop_on;
    res.loop_reference = st_nxt.use_ramp_reference ? st_nxt.ramp_reference
                                                   : item.target_ref;
    res.peripheral_cmd = cmd;
  end

endmodule

`default_nettype wire
